@@ hw/rtl/pce_pkg.sv @@
// ============================================================================
// pce_pkg
// Shared types and constants for the pairwise Coulomb energy core.
// ============================================================================
package pce_pkg;

    localparam logic [31:0] GammaReset = 32'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_DIV_SETUP,
        ST_DIV,
        ST_ACC,
        ST_RES_SETUP,
        ST_RES_DIV,
        ST_RES_FIN,
        ST_OUT
    } pce_state_t;

    // Operation requested from the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num_hi;
        logic [63:0] num_lo;
        logic [63:0] den;
    } pce_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo_hi;
        logic [63:0] quo_lo;
    } pce_div_rsp_t;

endpackage

@@ hw/rtl/pce_divider.sv @@
// ============================================================================
// pce_divider
// Radix-2 restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle.
// ============================================================================
module pce_divider
    import pce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  pce_div_req_t req,
    output pce_div_rsp_t rsp
);

    logic [127:0] quo_reg, quo_next;
    logic [64:0]  rem_reg, rem_next;
    logic [63:0]  den_reg, den_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [64:0]  trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[63:0], quo_reg[127]};
        if (req.start)
        begin
            quo_next  = {req.num_hi, req.num_lo};
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 8'd128;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[126:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[126:0], 1'b0};
            end
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.quo_hi = quo_reg[127:64];
    assign rsp.quo_lo = quo_reg[63:0];

`ifndef ASSERT_OFF
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !rsp.busy) else $error("divider done while busy");
    a_count_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == 8'd0 || $past(req.start) == 1'b0))
        else $error("divider count");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg)) else $error("done without work");
`endif

endmodule

@@ hw/rtl/pairwise_coulomb_energy_core.sv @@
// ============================================================================
// pairwise_coulomb_energy_core
// Direct Coulomb energy sum over ion pairs with a shared iterative divider.
// ============================================================================
// Channel | Direction | Handshake
// in      | input     | in_valid / in_stall, one pair per beat
// out     | output    | out_valid / out_stall, one result per last beat
// cfg     | input     | gamma_we / gamma_wdata, no wait
// A pair is squared and rooted, then divided unless the root or the charge product is
// zero; after the last pair the sum is divided by gamma unless gamma is zero.
// Reset clears the sum, its flag and gamma to 1.0.
// The input is stalled while a beat is in work or a result waits.
module pairwise_coulomb_energy_core
    import pce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               gamma_we,
    input  logic [31:0]        gamma_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [7:0]  charge_a,
    input  logic signed [7:0]  charge_b,
    input  logic               real_a,
    input  logic               real_b,
    input  logic signed [31:0] disp_x,
    input  logic signed [31:0] disp_y,
    input  logic signed [31:0] disp_z,
    input  logic               last_pair,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] energy,
    output logic               saturated
);

    pce_state_t   state_reg, state_next;
    logic [31:0]  gamma_reg;
    logic [63:0]  sum_reg, sum_next;
    logic         sat_reg, sat_next;
    logic [31:0]  ax_reg, ay_reg, az_reg;
    logic [16:0]  num_reg;
    logic         neg_reg, last_reg;
    logic [1:0]   sq_cnt_reg, sq_cnt_next;
    logic [63:0]  s_reg, s_next;
    logic [63:0]  root_reg, root_next;
    logic [63:0]  one_reg, one_next;
    logic [63:0]  res_reg, res_next;
    logic         rsat_reg, rsat_next;
    logic [31:0]  sq_op;
    logic [63:0]  sq_prod;
    logic [63:0]  rplus;
    logic [63:0]  abs_sum;
    logic         accepted;
    logic signed [15:0] qq;
    logic signed [17:0] qqw;
    logic [63:0]  term;
    logic         term_sat;
    logic [64:0]  add_wide;
    pce_div_req_t dreq;
    pce_div_rsp_t drsp;

    pce_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign accepted = in_valid && !in_stall;
    assign qq       = charge_a * charge_b;
    assign qqw      = 18'(qq) * $signed({16'd0, real_a} + {16'd0, real_b});
    assign abs_sum  = sum_reg[63] ? (64'd0 - sum_reg) : sum_reg;

    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sq_op = ax_reg;
            2'd1:    sq_op = ay_reg;
            default: sq_op = az_reg;
        endcase
        sq_prod = 64'(sq_op) * 64'(sq_op);
        rplus   = root_reg + one_reg;
    end

    // Term clamp and saturating add.
    always_comb
    begin
        term_sat = 1'b0;
        term     = drsp.quo_lo;
        if (drsp.quo_hi != 64'd0 || drsp.quo_lo > {1'b0, {63{1'b1}}})
        begin
            if (!neg_reg || drsp.quo_hi != 64'd0 || drsp.quo_lo != {1'b1, 63'd0})
                term_sat = 1'b1;
            term = neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else if (neg_reg)
        begin
            term = 64'd0 - drsp.quo_lo;
        end
        add_wide = {sum_reg[63], sum_reg} + {term[63], term};
    end

    always_comb
    begin
        state_next  = state_reg;
        sq_cnt_next = sq_cnt_reg;
        s_next      = s_reg;
        root_next   = root_reg;
        one_next    = one_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accepted)
                begin
                    state_next  = ST_SQ;
                    sq_cnt_next = 2'd0;
                    s_next      = '0;
                end
            end
            ST_SQ:
            begin
                s_next      = s_reg + sq_prod;
                sq_cnt_next = sq_cnt_reg + 2'd1;
                if (sq_cnt_reg == 2'd2)
                begin
                    root_next  = '0;
                    one_next   = {2'b01, 62'd0};
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (s_reg >= rplus)
                begin
                    s_next    = s_reg - rplus;
                    root_next = (root_reg >> 1) + one_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                one_next = one_reg >> 2;
                if (one_reg[0])
                    state_next = ST_DIV_SETUP;
            end
            ST_DIV_SETUP:
            begin
                if (root_reg == 64'd0 || num_reg == 17'd0)
                    state_next = last_reg ? ST_RES_SETUP : ST_IDLE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (drsp.done)
                    state_next = last_reg ? ST_RES_SETUP : ST_IDLE;
            end
            ST_RES_SETUP:
            begin
                state_next = (gamma_reg == 32'd0) ? ST_RES_FIN : ST_RES_DIV;
            end
            ST_RES_DIV:
            begin
                if (drsp.done)
                    state_next = ST_RES_FIN;
            end
            ST_RES_FIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dreq        = '0;
        sum_next    = sum_reg;
        sat_next    = sat_reg;
        res_next    = res_reg;
        rsat_next   = rsat_reg;
        case (state_reg)
            ST_DIV_SETUP:
            begin
                dreq.start  = (root_reg != 64'd0) && (num_reg != 17'd0);
                dreq.num_hi = 64'(num_reg[16]);
                dreq.num_lo = {num_reg[15:0], 48'd0};
                dreq.den    = root_reg;
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    sat_next = sat_reg | term_sat;
                    if (add_wide[64] != add_wide[63])
                    begin
                        sat_next = 1'b1;
                        sum_next = add_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end
                    else
                    begin
                        sum_next = add_wide[63:0];
                    end
                end
            end
            ST_RES_SETUP:
            begin
                dreq.start  = (gamma_reg != 32'd0);
                dreq.num_hi = 64'(abs_sum >> 49);
                dreq.num_lo = {abs_sum[48:0], 15'd0};
                dreq.den    = 64'(gamma_reg);
            end
            ST_RES_FIN:
            begin
                rsat_next = sat_reg;
                if (gamma_reg == 32'd0)
                begin
                    if (abs_sum == 64'd0)
                        res_next = '0;
                    else
                    begin
                        rsat_next = 1'b1;
                        res_next  = sum_reg[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end
                end
                else if (drsp.quo_hi != 64'd0 || drsp.quo_lo > {1'b0, {63{1'b1}}})
                begin
                    if (!sum_reg[63] || drsp.quo_hi != 64'd0
                        || drsp.quo_lo != {1'b1, 63'd0})
                        rsat_next = 1'b1;
                    res_next = sum_reg[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end
                else
                begin
                    res_next = sum_reg[63] ? (64'd0 - drsp.quo_lo) : drsp.quo_lo;
                end
                sum_next = '0;
                sat_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            gamma_reg  <= GammaReset;
            sum_reg    <= '0;
            sat_reg    <= 1'b0;
            sq_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            sat_reg    <= sat_next;
            sq_cnt_reg <= sq_cnt_next;
            if (gamma_we)
                gamma_reg <= gamma_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        root_reg <= root_next;
        one_reg  <= one_next;
        res_reg  <= res_next;
        rsat_reg <= rsat_next;
        if (accepted)
        begin
            ax_reg   <= disp_x[31] ? (32'd0 - disp_x) : disp_x;
            ay_reg   <= disp_y[31] ? (32'd0 - disp_y) : disp_y;
            az_reg   <= disp_z[31] ? (32'd0 - disp_z) : disp_z;
            num_reg  <= qqw[17] ? 17'(18'd0 - qqw) : 17'(qqw);
            neg_reg  <= qqw[17];
            last_reg <= last_pair;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign energy    = res_reg;
    assign saturated = rsat_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open while result waits");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(energy))
        else $error("result dropped");
    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RES_FIN |=> sum_reg == 64'd0 && !sat_reg)
        else $error("sum not cleared");
`endif

endmodule

@@ tb/pce_energy_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pce_energy_checker
// Watches the pair and result channels of the Coulomb energy core, keeps its
// own running energy sum and gamma copy, and compares every result beat with
// the oldest predicted energy and saturation flag. Mismatches are counted for the top level.
// ============================================================================
module pce_energy_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               gamma_we,
    input  logic [31:0]        gamma_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [7:0]  charge_a,
    input  logic signed [7:0]  charge_b,
    input  logic               real_a,
    input  logic               real_b,
    input  logic signed [31:0] disp_x,
    input  logic signed [31:0] disp_y,
    input  logic signed [31:0] disp_z,
    input  logic               last_pair,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [63:0] energy,
    input  logic               saturated,
    output int                 errors,
    output int                 pending
);
    localparam logic [63:0] MinMag = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] PosLimit = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] NegLimit = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [63:0] energy;
        logic               saturated;
    } energy_result_t;

    logic [31:0]        gamma_copy;
    logic signed [63:0] running_sum;
    logic               running_sat;
    energy_result_t     expected_energy[$];

    assign pending = expected_energy.size();

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] op);
        logic [63:0] root;
        logic [63:0] bit_val;
        root = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > op)
            bit_val >>= 2;
        while (bit_val != 0)
        begin
            if (op >= root + bit_val)
            begin
                op -= root + bit_val;
                root = (root >> 1) + bit_val;
            end
            else
                root >>= 1;
            bit_val >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] clamp_signed(input logic neg, input logic [63:0] mag,
                                                         inout logic flag);
        if (!neg)
        begin
            if (mag > 64'(PosLimit))
            begin
                flag = 1'b1;
                return PosLimit;
            end
            return mag;
        end
        if (mag > MinMag)
            flag = 1'b1;
        if (mag >= MinMag)
            return NegLimit;
        return -$signed(mag);
    endfunction

    task automatic accumulate_pair();
        logic signed [63:0] qa, qb, num, term, sum_next;
        logic [63:0] ax, ay, az, sq, root, mag;
        logic [127:0] wide;
        qa = charge_a;
        qb = charge_b;
        num = qa * qb * (64'(real_a) + 64'(real_b));
        ax = magnitude(64'(disp_x));
        ay = magnitude(64'(disp_y));
        az = magnitude(64'(disp_z));
        sq = ax * ax + ay * ay + az * az;
        if (sq != 0 && num != 0)
        begin
            root = int_sqrt(sq);
            wide = {64'd0, magnitude(num)} << 48;
            mag = 64'(wide / root);
            term = clamp_signed(num < 0, mag, running_sat);
            sum_next = running_sum + term;
            if (term > 0 && running_sum > PosLimit - term)
            begin
                running_sat = 1'b1;
                sum_next = PosLimit;
            end
            else if (term < 0 && running_sum < NegLimit - term)
            begin
                running_sat = 1'b1;
                sum_next = NegLimit;
            end
            running_sum = sum_next;
        end
        if (last_pair)
            close_sum();
    endtask

    task automatic close_sum();
        energy_result_t res;
        logic neg, over;
        logic [63:0] m;
        logic [127:0] q;
        res.saturated = running_sat;
        neg = running_sum < 0;
        m = magnitude(running_sum);
        if (gamma_copy == 0)
        begin
            if (m == 0)
                res.energy = 0;
            else
            begin
                res.saturated = 1'b1;
                res.energy = neg ? NegLimit : PosLimit;
            end
        end
        else
        begin
            q = ({64'd0, m} << 15) / gamma_copy;
            over = q[127:64] != 0;
            if (over)
            begin
                res.saturated = 1'b1;
                res.energy = neg ? NegLimit : PosLimit;
            end
            else
                res.energy = clamp_signed(neg, q[63:0], res.saturated);
        end
        expected_energy.push_back(res);
        running_sum = 0;
        running_sat = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        energy_result_t want;
        if (!rst_n)
        begin
            gamma_copy = 32'd65536;
            running_sum = 0;
            running_sat = 1'b0;
            errors = 0;
            expected_energy.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_energy.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat energy=%0d saturated=%0b",
                             $time, energy, saturated);
                end
                else
                begin
                    want = expected_energy.pop_front();
                    if (energy !== want.energy)
                    begin
                        errors++;
                        $display("%0t: energy expected %0d actual %0d",
                                 $time, want.energy, energy);
                    end
                    if (saturated !== want.saturated)
                    begin
                        errors++;
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.saturated, saturated);
                    end
                end
            end
            if (gamma_we)
                gamma_copy = gamma_wdata;
            if (in_valid && !in_stall)
                accumulate_pair();
        end
    end
endmodule

@@ tb/tb_pairwise_coulomb_energy_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_pairwise_coulomb_energy_core
// Drives ion pair beats and gamma settings into the Coulomb energy core under
// several idle and stall mixes; a checker beside the core predicts results.
// ============================================================================
module tb_pairwise_coulomb_energy_core;
    import pce_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               gamma_we;
    logic [31:0]        gamma_wdata;
    logic               in_valid;
    logic               in_stall;
    logic signed [7:0]  charge_a;
    logic signed [7:0]  charge_b;
    logic               real_a;
    logic               real_b;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic               last_pair;
    logic               out_valid;
    logic               out_stall;
    logic signed [63:0] energy;
    logic               saturated;
    int                 errors;
    int                 pending;
    int                 stall_pct;

    pairwise_coulomb_energy_core dut (.*);
    pce_energy_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    initial
    begin
        #400ms;
        $display("[pairwise_coulomb_energy_core] ERROR");
        $finish;
    end

    task automatic send_pair(input logic [7:0] qa, input logic [7:0] qb, input logic ra,
                             input logic rb, input logic [31:0] dx, input logic [31:0] dy,
                             input logic [31:0] dz, input logic lst, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        charge_a <= qa;
        charge_b <= qb;
        real_a <= ra;
        real_b <= rb;
        disp_x <= dx;
        disp_y <= dy;
        disp_z <= dz;
        last_pair <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_disp();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'(int'($urandom_range(8)) - 4) <<< 16;
            2: return {{16{1'b0}}, 16'($urandom)};
            3: return 32'($urandom_range(65535)) - 32'd32768;
            default: return 32'(int'($urandom_range(200)) - 100) <<< 16;
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_gamma(input logic [31:0] value);
        gamma_we <= 1'b1;
        gamma_wdata <= value;
        @(negedge clk);
        gamma_we <= 1'b0;
    endtask

    task automatic random_phase(input int count, input int idle_pct);
        int n;
        for (n = 0; n < count; n++)
            send_pair(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), rand_disp(),
                      rand_disp(), rand_disp(), $urandom_range(5) == 0, idle_pct);
        send_pair(8'($urandom), 8'($urandom), 1'b1, 1'b0, rand_disp(), rand_disp(),
                  rand_disp(), 1'b1, idle_pct);
    endtask

    initial
    begin
        rst_n = 1'b0;
        gamma_we = 1'b0;
        gamma_wdata = '0;
        in_valid = 1'b0;
        charge_a = '0;
        charge_b = '0;
        real_a = 1'b0;
        real_b = 1'b0;
        disp_x = '0;
        disp_y = '0;
        disp_z = '0;
        last_pair = 1'b0;
        stall_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pair(8'sd127, 8'sd127, 1'b1, 1'b1, 32'h0001_0000, 32'd0, 32'd0, 1'b0, 0);
        send_pair(8'sh80, 8'sh80, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 1'b0, 0);
        send_pair(8'sh80, 8'sd127, 1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  1'b1, 0);
        send_pair(8'sh80, 8'sh80, 1'b1, 1'b1, 32'd1, 32'd0, 32'd0, 1'b0, 0);
        send_pair(8'sh80, 8'sh80, 1'b1, 1'b1, 32'd0, 32'd1, 32'd0, 1'b0, 0);
        send_pair(8'sh80, 8'sh80, 1'b1, 1'b1, 32'd0, 32'd0, 32'd1, 1'b1, 0);
        send_pair(8'sd0, 8'sd5, 1'b1, 1'b1, 32'h0002_0000, 32'd0, 32'd0, 1'b0, 0);
        send_pair(8'sd3, 8'sd5, 1'b0, 1'b0, 32'h0002_0000, 32'd0, 32'd0, 1'b1, 0);
        send_pair(8'sd3, -8'sd5, 1'b0, 1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'd0, 1'b1, 0);
        send_pair(8'sh80, 8'sd127, 1'b1, 1'b1, 32'd1, 32'd0, 32'd0, 1'b1, 0);
        send_pair(-8'sd1, 8'sd1, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  1'b1, 0);
        wait_drained();
        write_gamma(32'd0);
        send_pair(8'sd1, 8'sd1, 1'b1, 1'b1, 32'h0001_0000, 32'd0, 32'd0, 1'b1, 0);
        send_pair(-8'sd1, 8'sd1, 1'b1, 1'b1, 32'h0001_0000, 32'd0, 32'd0, 1'b1, 0);
        send_pair(8'sd0, 8'sd1, 1'b1, 1'b1, 32'h0001_0000, 32'd0, 32'd0, 1'b1, 0);
        wait_drained();
        write_gamma(32'd1);
        send_pair(8'sd7, 8'sd9, 1'b1, 1'b1, 32'h0000_8000, 32'd0, 32'd0, 1'b1, 0);
        send_pair(-8'sd7, 8'sd9, 1'b1, 1'b0, 32'h0000_0100, 32'd0, 32'd0, 1'b1, 0);
        wait_drained();
        write_gamma(32'hFFFF_FFFF);
        send_pair(8'sd127, 8'sd127, 1'b1, 1'b1, 32'd1, 32'd0, 32'd0, 1'b1, 0);
        send_pair(8'sd2, -8'sd3, 1'b1, 1'b1, 32'h0003_0000, 32'h0004_0000, 32'd0, 1'b1, 0);
        wait_drained();

        write_gamma(32'd65536);
        random_phase(160, 0);
        wait_drained();
        write_gamma($urandom_range(32'h0020_0000, 1));
        random_phase(160, 53);
        wait_drained();
        write_gamma($urandom);
        stall_pct = 53;
        random_phase(160, 0);
        wait_drained();
        write_gamma(32'h0000_8000);
        stall_pct = 14;
        random_phase(150, 14);
        wait_drained();

        if (errors == 0)
            $display("[pairwise_coulomb_energy_core] OK");
        else
            $display("[pairwise_coulomb_energy_core] ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/pce_pkg.sv
hw/rtl/pce_divider.sv
hw/rtl/pairwise_coulomb_energy_core.sv
tb/pce_energy_checker.sv
tb/tb_pairwise_coulomb_energy_core.sv
